// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the console rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tcce_pkg.sv =====
// types and constants of the text console cursor engine
`timescale 1ns / 1ps

package tcce_pkg;

	// field widths
	localparam int CHAR_W     = 8;
	localparam int ATTR_W     = 8;
	localparam int CELL_W     = 16;
	localparam int INDEX_W    = 11;
	localparam int ROW_OUT_W  = 5;
	localparam int COL_OUT_W  = 7;

	// stream packing
	localparam int IN_DATA_W  = 24;
	localparam int IN_USER_W  = 1;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_PAD_W  = OUT_DATA_W - CELL_W - ROW_OUT_W - COL_OUT_W - INDEX_W;

	// register port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_WORD_W = APB_ADDR_W - 2;
	localparam logic [REG_WORD_W-1:0] REG_TEXT_ATTR = 1'b0;

	// character and request codes
	localparam logic [CHAR_W-1:0] NUL_CODE     = 8'h00;
	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;
	localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0c;
	localparam logic REQ_PUT  = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BLANK,
		ST_FINISH
	} tcce_state_t;

endpackage

// ===== rtl/core/text_console_cursor_engine_top.sv =====
// text console cursor engine: screen memory, cursor and scroll control
`timescale 1ns / 1ps

// Text-mode console of ROWS x COLUMNS 16-bit cells (attribute high byte, character low
// byte) held in one single-port-write, single-port-read synchronous memory. Screen rows
// are kept as a ring: scrolling moves the base of the top row and blanks the row that
// becomes the bottom one, so no cell is ever copied. A put or a read request is taken
// in the idle state; its result is then loaded into the output register from the finish
// state once that register is free. A put that scrolls first blanks the new bottom row,
// one blank cell written per cycle through the memory's single write port. After reset
// the block clears the whole screen, one cell a cycle, before it accepts the first
// request; register writes are taken during that time. The next request is accepted
// while a result still waits on the output side. s_tuser[0] is the request type (0 put,
// 1 read); a read of a cell index at or beyond ROWS*COLUMNS returns 0.
module text_console_cursor_engine_top #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [7:0] char_code, [18:8] cell_index, [23:19] zero
	input  logic [tcce_pkg::IN_DATA_W-1:0]    s_tdata,
	// [0] req_type
	input  logic [tcce_pkg::IN_USER_W-1:0]    s_tuser,
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [15:0] cell_value, [20:16] cursor_row, [27:21] cursor_col,
	// [38:28] cursor_index, [39] zero
	output logic [tcce_pkg::OUT_DATA_W-1:0]   m_tdata,
	// register port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tcce_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [tcce_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [tcce_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);

	`include "assert_macros.svh"

	localparam int CELLS         = ROWS * COLUMNS;
	localparam int AW            = $clog2(CELLS);
	localparam int RW            = $clog2(ROWS);
	localparam int CLW           = $clog2(COLUMNS);
	localparam int IDX_W         = tcce_pkg::INDEX_W;
	localparam int SW            = ((AW > IDX_W) ? AW : IDX_W) + 1;
	localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;
	localparam int ROW_W         = tcce_pkg::ROW_OUT_W;
	localparam int COL_W         = tcce_pkg::COL_OUT_W;
	localparam int CELL_W        = tcce_pkg::CELL_W;
	localparam int CHAR_W        = tcce_pkg::CHAR_W;
	localparam int ATTR_W        = tcce_pkg::ATTR_W;
	localparam int DATA_W        = tcce_pkg::APB_DATA_W;

	tcce_pkg::tcce_state_t state_q, state_d;

	logic [CELL_W-1:0] screen_q [CELLS];
	logic [CELL_W-1:0] rdata_q;

	logic [ATTR_W-1:0] attr_q;
	logic [RW-1:0]     cur_row_q, cur_row_d;
	logic [CLW-1:0]    cur_col_q, cur_col_d;
	logic [AW-1:0]     cur_lin_q, cur_lin_d;
	logic [AW-1:0]     top_base_q, top_base_d;
	logic [AW-1:0]     sweep_q, sweep_d;
	logic [AW-1:0]     sweep_last_q, sweep_last_d;

	logic is_read_s1;
	logic hit_s1;

	logic                  out_valid_q;
	logic [tcce_pkg::OUT_DATA_W-1:0] out_data_q;
	logic                  out_load;

	logic              in_accept;
	logic              in_read;
	logic [CHAR_W-1:0] in_char;
	logic [IDX_W-1:0]  in_idx;
	logic              in_range;

	logic [SW-1:0] rd_sum, rd_wrap;
	logic [SW-1:0] cur_sum, cur_wrap;
	logic [SW-1:0] top_sum, top_wrap;
	logic [SW-1:0] lin_nl;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] cur_phys;
	logic          at_last_col;
	logic          at_last_row;

	logic              mem_we;
	logic              mem_re;
	logic [AW-1:0]     mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic [CELL_W-1:0] cell_out;
	logic              cfg_wr;

	// request fields
	assign in_read   = s_tuser[0];
	assign in_char   = s_tdata[CHAR_W-1:0];
	assign in_idx    = s_tdata[CHAR_W +: IDX_W];
	assign s_tready  = (state_q == tcce_pkg::ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign in_range  = SW'(in_idx) < SW'(CELLS);

	// logical to physical address through the ring base
	assign rd_sum   = SW'(in_idx) + SW'(top_base_q);
	assign rd_wrap  = (rd_sum >= SW'(CELLS)) ? rd_sum - SW'(CELLS) : rd_sum;
	assign rd_addr  = rd_wrap[AW-1:0];
	assign cur_sum  = SW'(cur_lin_q) + SW'(top_base_q);
	assign cur_wrap = (cur_sum >= SW'(CELLS)) ? cur_sum - SW'(CELLS) : cur_sum;
	assign cur_phys = cur_wrap[AW-1:0];
	assign top_sum  = SW'(top_base_q) + SW'(COLUMNS);
	assign top_wrap = (top_sum >= SW'(CELLS)) ? top_sum - SW'(CELLS) : top_sum;
	// start of the next row, used only when no scroll follows
	assign lin_nl   = SW'(cur_lin_q) - SW'(cur_col_q) + SW'(COLUMNS);

	assign at_last_col = (cur_col_q == CLW'(COLUMNS - 1));
	assign at_last_row = (cur_row_q == RW'(ROWS - 1));

	assign out_load = !out_valid_q || m_tready;
	assign mem_re   = in_accept && (in_read == tcce_pkg::REQ_READ) && in_range;

	always_comb begin
		state_d      = state_q;
		cur_row_d    = cur_row_q;
		cur_col_d    = cur_col_q;
		cur_lin_d    = cur_lin_q;
		top_base_d   = top_base_q;
		sweep_d      = sweep_q;
		sweep_last_d = sweep_last_q;
		mem_we       = 1'b0;
		mem_waddr    = sweep_q;
		mem_wdata    = {attr_q, tcce_pkg::NUL_CODE};
		unique case (state_q)
			tcce_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = {tcce_pkg::ATTR_RESET, tcce_pkg::NUL_CODE};
				if (sweep_q == sweep_last_q) begin
					state_d = tcce_pkg::ST_IDLE;
				end else begin
					sweep_d = sweep_q + 1'b1;
				end
			end
			tcce_pkg::ST_BLANK: begin
				mem_we = 1'b1;
				if (sweep_q == sweep_last_q) begin
					state_d = tcce_pkg::ST_FINISH;
				end else begin
					sweep_d = sweep_q + 1'b1;
				end
			end
			tcce_pkg::ST_IDLE: begin
				if (in_accept) begin
					state_d = tcce_pkg::ST_FINISH;
					if ((in_read == tcce_pkg::REQ_PUT) && (in_char != tcce_pkg::NUL_CODE)) begin
						if (in_char != tcce_pkg::NEWLINE_CODE) begin
							mem_we    = 1'b1;
							mem_waddr = cur_phys;
							mem_wdata = {attr_q, in_char};
						end
						if ((in_char == tcce_pkg::NEWLINE_CODE) || at_last_col) begin
							cur_col_d = '0;
							if (at_last_row) begin
								// old top row becomes the blank bottom row
								cur_lin_d    = AW'(LAST_ROW_BASE);
								top_base_d   = top_wrap[AW-1:0];
								sweep_d      = top_base_q;
								sweep_last_d = top_base_q + AW'(COLUMNS - 1);
								state_d      = tcce_pkg::ST_BLANK;
							end else begin
								cur_row_d = cur_row_q + 1'b1;
								cur_lin_d = lin_nl[AW-1:0];
							end
						end else begin
							cur_col_d = cur_col_q + 1'b1;
							cur_lin_d = cur_lin_q + 1'b1;
						end
					end
				end
			end
			tcce_pkg::ST_FINISH: begin
				if (out_load) begin
					state_d = tcce_pkg::ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tcce_pkg::ST_CLEAR;
			cur_row_q    <= '0;
			cur_col_q    <= '0;
			cur_lin_q    <= '0;
			top_base_q   <= '0;
			sweep_q      <= '0;
			sweep_last_q <= AW'(CELLS - 1);
		end else begin
			state_q      <= state_d;
			cur_row_q    <= cur_row_d;
			cur_col_q    <= cur_col_d;
			cur_lin_q    <= cur_lin_d;
			top_base_q   <= top_base_d;
			sweep_q      <= sweep_d;
			sweep_last_q <= sweep_last_d;
		end
	end

	// screen memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			screen_q[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_q <= screen_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			is_read_s1 <= in_read;
			hit_s1     <= in_range;
		end
	end

	// output register
	assign cell_out = ((is_read_s1 == tcce_pkg::REQ_READ) && hit_s1) ? rdata_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == tcce_pkg::ST_FINISH) && out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == tcce_pkg::ST_FINISH) && out_load) begin
			out_data_q <= {{tcce_pkg::OUT_PAD_W{1'b0}}, IDX_W'(cur_lin_q),
				COL_W'(cur_col_q), ROW_W'(cur_row_q), cell_out};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcce_pkg::ATTR_RESET;
		end else if (cfg_wr && (paddr[2 +: tcce_pkg::REG_WORD_W] == tcce_pkg::REG_TEXT_ATTR)) begin
			attr_q <= pwdata[ATTR_W-1:0];
		end
	end

	assign prdata = (paddr[2 +: tcce_pkg::REG_WORD_W] == tcce_pkg::REG_TEXT_ATTR) ?
		DATA_W'(attr_q) : '0;

	`ASSERT_IMPLY(a_cursor_lin, clk, arst_n, 1'b1, int'(cur_lin_q) == int'(cur_row_q) * COLUMNS + int'(cur_col_q), "cursor index out of step with row and column")
	`ASSERT_IMPLY(a_cursor_bounds, clk, arst_n, 1'b1, (int'(cur_col_q) < COLUMNS) && (int'(cur_row_q) < ROWS), "cursor outside the screen")
	`ASSERT_IMPLY(a_ring_base, clk, arst_n, 1'b1, int'(top_base_q) <= CELLS - COLUMNS, "top row base outside the screen memory")
	`ASSERT_NEXT(a_one_request, clk, arst_n, in_accept, state_q != tcce_pkg::ST_IDLE, "request accepted while another is in flight")

endmodule
